### hw/rtl/prpf_pkg.sv
`timescale 1ns / 1ps

package prpf_pkg;

  // Default values of the top level parameters.
  localparam int unsigned DEF_MAX_PATTERN_LEN = 32;
  localparam int unsigned DEF_PATTERN_SLOTS   = 4;
  localparam int unsigned DEF_MAX_READ_LEN    = 65535;
  localparam int unsigned DEF_QUEUE_DEPTH     = 2;

  // Fixed field widths.
  localparam int unsigned HIST_W   = 64;
  localparam int unsigned RUN_W    = 6;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned SLOTS    = 4;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BEGIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ZERO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ONE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_TWO     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_THREE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTHS = 3'd6;

  // ASCII characters that count as bases, and their 2-bit codes.
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // One classified base as it passes from the front to the back.
  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic [RUN_W-1:0]  run;
    logic [POS_W-1:0]  pos;
    logic              compare;
    logic              last;
    logic              second;
  } prpf_entry_t;

endpackage

### hw/rtl/prpf_front.sv
`timescale 1ns / 1ps

module prpf_front import prpf_pkg::*; #(
  parameter int unsigned MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
  parameter int unsigned MAX_READ_LEN    = DEF_MAX_READ_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAR_W-1:0] base_char_i,
  input  logic              from_second_read_i,
  input  logic              last_of_read_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output prpf_entry_t       push_entry_o
);

  logic [HIST_W-1:0] hist_q, hist_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              is_base;
  logic [1:0]        code;
  logic              in_range;
  logic [RUN_W-1:0]  run_inc;
  logic              accept;

  always_comb begin
    is_base = 1'b1;
    code    = CODE_A;
    unique case (base_char_i)
      CHAR_A: code = CODE_A;
      CHAR_C: code = CODE_C;
      CHAR_G: code = CODE_G;
      CHAR_T: code = CODE_T;
      default: is_base = 1'b0;
    endcase
  end

  assign in_range = pos_q < POS_W'(MAX_READ_LEN);
  assign run_inc  = (run_q < RUN_W'(MAX_PATTERN_LEN)) ? run_q + RUN_W'(1) : run_q;

  always_comb begin
    push_entry_o.compare = in_range && is_base;
    push_entry_o.hist    = push_entry_o.compare ? {code, hist_q[HIST_W-1:2]} : hist_q;
    push_entry_o.run     = push_entry_o.compare ? run_inc : '0;
    push_entry_o.pos     = pos_q;
    push_entry_o.last    = last_of_read_i;
    push_entry_o.second  = from_second_read_i;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    hist_d = hist_q;
    run_d  = run_q;
    pos_d  = pos_q;
    if (accept) begin
      if (last_of_read_i) begin
        hist_d = '0;
        run_d  = '0;
        pos_d  = '0;
      end else begin
        hist_d = push_entry_o.hist;
        run_d  = push_entry_o.run;
        pos_d  = in_range ? pos_q + POS_W'(1) : pos_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      run_q  <= '0;
      pos_q  <= '0;
    end else begin
      hist_q <= hist_d;
      run_q  <= run_d;
      pos_q  <= pos_d;
    end
  end

endmodule

### hw/rtl/prpf_queue.sv
`timescale 1ns / 1ps

module prpf_queue import prpf_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  prpf_entry_t push_entry_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output prpf_entry_t pop_entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  prpf_entry_t       mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/prpf_back.sv
`timescale 1ns / 1ps

module prpf_back import prpf_pkg::*; #(
  parameter int unsigned MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
  parameter int unsigned PATTERN_SLOTS   = DEF_PATTERN_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  prpf_entry_t           pop_entry_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  remove_pair_o,
  output logic [COUNT_W-1:0]    removed_total_o
);

  localparam int unsigned STOP_W = POS_W + 1;
  localparam int unsigned SH_W   = $clog2(HIST_W) + 1;

  logic [POS_W-1:0]       win_begin_q, win_end_q;
  logic [HIST_W-1:0]      pat_q [SLOTS];
  logic [SLOTS*LEN_W-1:0] lens_q;
  logic                   pair_hit_q, pair_hit_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic                   remove_q, remove_d;
  logic [PATTERN_SLOTS-1:0] slot_hit;
  logic [STOP_W-1:0]      stop;
  logic                   hit_now;
  logic                   do_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_begin_q <= '0;
      win_end_q   <= '1;
      for (int i = 0; i < SLOTS; i++) begin
        pat_q[i] <= '0;
      end
      lens_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_BEGIN:    win_begin_q <= cfg_data_i[POS_W-1:0];
        CFG_WINDOW_END:      win_end_q   <= cfg_data_i[POS_W-1:0];
        CFG_PATTERN_ZERO:    pat_q[0]    <= cfg_data_i;
        CFG_PATTERN_ONE:     pat_q[1]    <= cfg_data_i;
        CFG_PATTERN_TWO:     pat_q[2]    <= cfg_data_i;
        CFG_PATTERN_THREE:   pat_q[3]    <= cfg_data_i;
        CFG_PATTERN_LENGTHS: lens_q      <= cfg_data_i[SLOTS*LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign stop = STOP_W'(pop_entry_i.pos) + STOP_W'(1);

  // The newest len bases sit at the top of the history; the pattern's first base
  // is in its low bits, so the pattern moves up by the same amount for the compare.
  for (genvar s = 0; s < PATTERN_SLOTS; s++) begin : g_slot
    logic [LEN_W-1:0]  len;
    logic [SH_W-1:0]   sh;
    logic [HIST_W-1:0] top_mask;
    logic              len_ok, win_ok;

    assign len      = lens_q[s*LEN_W +: LEN_W];
    assign sh       = SH_W'(HIST_W) - {len, 1'b0};
    assign top_mask = {HIST_W{1'b1}} << sh;
    assign len_ok   = (len != '0) && (len <= LEN_W'(MAX_PATTERN_LEN))
                      && (pop_entry_i.run >= len) && (stop >= STOP_W'(len));
    assign win_ok   = ((stop - STOP_W'(len)) >= STOP_W'(win_begin_q))
                      && (stop <= STOP_W'(win_end_q));
    assign slot_hit[s] = len_ok && win_ok
                         && ((pop_entry_i.hist & top_mask) == ((pat_q[s] << sh) & top_mask));
  end

  assign hit_now     = pair_hit_q || (pop_entry_i.compare && (slot_hit != '0));
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign do_pop      = pop_valid_i && pop_ready_o;

  always_comb begin
    pair_hit_d  = pair_hit_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    remove_d    = remove_q;
    if (do_pop) begin
      if (pop_entry_i.last && pop_entry_i.second) begin
        out_valid_d = 1'b1;
        remove_d    = hit_now;
        pair_hit_d  = 1'b0;
        if (hit_now && (count_q != '1)) begin
          count_d = count_q + COUNT_W'(1);
        end
      end else begin
        pair_hit_d = hit_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_hit_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pair_hit_q  <= pair_hit_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remove_q <= remove_d;
  end

  assign out_valid_o     = out_valid_q;
  assign remove_pair_o   = remove_q;
  assign removed_total_o = count_q;

endmodule

### hw/rtl/paired_read_pattern_filter_unit.sv
`timescale 1ns / 1ps
// Paired read pattern filter. Bases of a read pair stream in on the input channel,
// one word per cycle while in_ready_o is high: all bases of the first read, then
// those of the second, with last_of_read_i marking the final base of each read.
// Only uppercase A, C, G and T are bases; any other byte breaks the current run.
// The configuration channel writes the window and the four pattern slots; it is
// always ready and must only be used while no pair is in flight.
// One result word leaves on the output channel for the last base of the second
// read: remove_pair_o tells whether any pattern lay inside the window in either
// read, and removed_total_o is the saturating count of removed pairs so far.
// Throughput is one word per cycle while the output is not stalled, set by the
// combinational classify step in the front and the parallel slot compare in the
// back. An accepted word is stored in the queue; the result is registered in the back.
// When the receiver stalls, the result waits in the output register, the queue
// between front and back fills, and in_ready_o drops once it is full.
// Reset clears the history, run, position, pair flag and removed count, and sets
// the window to the full read with all pattern slots unused.

module paired_read_pattern_filter_unit import prpf_pkg::*; #(
  parameter int unsigned MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
  parameter int unsigned PATTERN_SLOTS   = DEF_PATTERN_SLOTS,
  parameter int unsigned MAX_READ_LEN    = DEF_MAX_READ_LEN,
  parameter int unsigned QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CHAR_W-1:0]     base_char_i,
  input  logic                  from_second_read_i,
  input  logic                  last_of_read_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  remove_pair_o,
  output logic [COUNT_W-1:0]    removed_total_o
);

  // Front to queue.
  logic        push_valid, push_ready;
  prpf_entry_t push_entry;
  // Queue to back.
  logic        pop_valid, pop_ready;
  prpf_entry_t pop_entry;

  // The front decodes each byte, keeps the base history and run length of the
  // current read, and tracks the position within the read.
  prpf_front #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .MAX_READ_LEN    (MAX_READ_LEN)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .base_char_i        (base_char_i),
    .from_second_read_i (from_second_read_i),
    .last_of_read_i     (last_of_read_i),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .push_entry_o       (push_entry)
  );

  // A short queue lets the front keep taking bases while the back waits on the
  // output channel.
  prpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // The back holds the configuration, compares every slot against the history,
  // collects the pair flag and delivers the result at the end of the pair.
  prpf_back #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .PATTERN_SLOTS   (PATTERN_SLOTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_entry_i     (pop_entry),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .remove_pair_o   (remove_pair_o),
    .removed_total_o (removed_total_o)
  );

endmodule

### tb/tb_paired_read_pattern_filter_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the paired read pattern filter.
//
// Stimulus is sent one word (one base) per handshake on the input channel, and the
// configuration channel loads the window and the four pattern slots between phases,
// only after every expected result word has come back and the pipeline has gone quiet.
// Every accepted base is fed to a local model of the filter, which tracks the base
// history, the run of valid bases, the read position, the pair flag and the removed
// count, and queues a verdict whenever the base closes the second read of a pair.
// Each result word is compared field by field against the oldest queued verdict.
//
// The run has four parts:
//   1. A short directed table: reset behavior, the extreme byte values, lowercase
//      and other non-bases, unused and overlong slots, a full-length slot, and flags
//      that arrive out of order.
//   2. Random phases, each with a fresh setting of every register: open, narrow,
//      empty or inverted windows, and slots of every length class. Reads are mostly
//      random ACGT with a slot's pattern dropped in at a random spot, plus stray bytes
//      and bursts of words with random flags.
//   3. In one phase the receiver holds off for a long stretch while short pairs keep
//      coming, so the internal queue fills and the input stalls.
//   4. A quiet tail with no idling: a fresh register setting and a few more random
//      pairs.

module tb_paired_read_pattern_filter_unit;
  import prpf_pkg::*;

  // Settle time allowed before touching registers.
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_WORDS   = 100;
  localparam int RANDOM_PHASES = 10;
  localparam int PRESSURE_PHASE = 3;

  typedef struct packed {
    logic              remove;
    logic [COUNT_W-1:0] total;
  } verdict_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              second;
    logic              last;
    logic              fixed;
    verdict_t          want;
  } probe_row_t;

  typedef enum int {
    SETUP_OPEN,
    SETUP_NARROW,
    SETUP_INVERTED,
    SETUP_LONG_MOTIFS,
    SETUP_CLOSED
  } setup_kind_e;

  localparam verdict_t NO_VERDICT = '0;
  // Rows before this index run on the reset configuration.
  localparam int PROBE_SETUP_ROW = 2;
  localparam int PROBE_ROWS      = 22;

  // Directed rows. Only the verdict right after reset is typed in; all others come
  // from the local model.
  localparam probe_row_t PROBE [PROBE_ROWS] = '{
    // A pair straight after reset: nothing is configured, so it is kept, count zero.
    '{CHAR_A, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{CHAR_T, 1'b1, 1'b1, 1'b1, '{1'b0, 32'd0}},
    // First read ACGT with a lowercase g in the middle: the run is broken, no hit.
    '{CHAR_A, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_C, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{"g",    1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_T, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    // Second read opens with a zero byte, then a clean ACGT hit.
    '{8'h00,  1'b1, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_A, 1'b1, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_C, 1'b1, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_G, 1'b1, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_T, 1'b1, 1'b1, 1'b0, NO_VERDICT},
    // Flags out of order: a second-read flag inside the first read. The hit in the
    // first read must survive until the pair closes on an all-ones byte.
    '{CHAR_A, 1'b1, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_C, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_T, 1'b0, 1'b1, 1'b0, NO_VERDICT},
    '{8'hFF,  1'b1, 1'b1, 1'b0, NO_VERDICT},
    // A one-base pair with no hit.
    '{CHAR_T, 1'b1, 1'b1, 1'b0, NO_VERDICT},
    // All A's: only the unused slot and the overlong slot could claim these.
    '{CHAR_A, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_A, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_A, 1'b0, 1'b0, 1'b0, NO_VERDICT},
    '{CHAR_A, 1'b1, 1'b1, 1'b0, NO_VERDICT}
  };

  // Block ports. Every input starts at a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     base_char = '0;
  logic                  from_second = 1'b0;
  logic                  last_of_read = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  remove_pair;
  logic [COUNT_W-1:0]    removed_total;

  // Local model of the filter: its copy of the registers and of the datapath state.
  int                 win_lo;
  int                 win_hi;
  logic [HIST_W-1:0]  motif [SLOTS];
  logic [SLOTS*LEN_W-1:0] motif_len;
  logic [HIST_W-1:0]  seen_bases;
  int                 run_len;
  int                 read_pos;
  bit                 pair_flag;
  logic [COUNT_W-1:0] removed_pairs;

  verdict_t pending_verdicts [$];
  verdict_t oldest;

  // Traffic shaping shared between the stimulus and the receiver.
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int tx_calm = 0;
  int rx_calm = 0;
  bit hold_req = 1'b0;
  bit holding = 1'b0;

  int errors = 0;
  int words_sent = 0;
  int phase_words = 0;
  int setups_loaded = 0;
  int results_checked = 0;
  int pairs_removed = 0;
  int input_stall_cycles = 0;

  paired_read_pattern_filter_unit uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .base_char_i        (base_char),
    .from_second_read_i (from_second),
    .last_of_read_i     (last_of_read),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .remove_pair_o      (remove_pair),
    .removed_total_o    (removed_total)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Timed out with %0d result words still outstanding.", pending_verdicts.size());
    $display("tb_paired_read_pattern_filter_unit: FAIL");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] code_char(input logic [1:0] code);
    case (code)
      CODE_A: return CHAR_A;
      CODE_C: return CHAR_C;
      CODE_G: return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  // Advances the local model by one accepted base. Returns 1 and fills the verdict
  // when the base closes the second read of a pair.
  function automatic bit filter_base(input logic [CHAR_W-1:0] ch, input logic second,
                                     input logic last, output verdict_t verdict);
    logic [1:0]        code;
    bit                is_base;
    int                stop;
    int                len;
    logic [HIST_W-1:0] window_bases;
    logic [HIST_W-1:0] mask;
    verdict = NO_VERDICT;
    is_base = 1'b1;
    case (ch)
      CHAR_A: code = CODE_A;
      CHAR_C: code = CODE_C;
      CHAR_G: code = CODE_G;
      CHAR_T: code = CODE_T;
      default: begin
        code = CODE_A;
        is_base = 1'b0;
      end
    endcase

    if (read_pos >= int'(DEF_MAX_READ_LEN)) begin
      // Past the end of a read the position sticks and nothing is compared.
      run_len = 0;
    end else begin
      if (is_base) begin
        seen_bases = {code, seen_bases[HIST_W-1:2]};
        if (run_len < int'(DEF_MAX_PATTERN_LEN)) run_len++;
        stop = read_pos + 1;
        for (int s = 0; s < SLOTS; s++) begin
          len = int'(motif_len[LEN_W*s +: LEN_W]);
          // The pattern must be whole, inside the run, and inside the window.
          if (len == 0 || len > int'(DEF_MAX_PATTERN_LEN)) continue;
          if (run_len < len || stop < len) continue;
          if (stop - len < win_lo || stop > win_hi) continue;
          window_bases = seen_bases >> (HIST_W - 2 * len);
          mask = (len == 32) ? '1 : ((64'd1 << (2 * len)) - 64'd1);
          if ((window_bases & mask) == (motif[s] & mask)) pair_flag = 1'b1;
        end
      end else begin
        run_len = 0;
      end
      read_pos++;
    end

    if (!last) return 1'b0;
    read_pos = 0;
    run_len = 0;
    seen_bases = '0;
    if (!second) return 1'b0;

    if (pair_flag && removed_pairs != '1) removed_pairs++;
    verdict.remove = pair_flag;
    verdict.total = removed_pairs;
    pair_flag = 1'b0;
    return 1'b1;
  endfunction

  // Pattern length for a random setup. Wild picks reach the full-length and
  // overlong classes; tame ones stay short so hits are common.
  function automatic logic [LEN_W-1:0] pick_len(input bit wild);
    int roll;
    roll = $urandom_range(0, 9);
    if (!wild) return LEN_W'($urandom_range(0, 6));
    case (roll)
      0: return '0;
      1: return LEN_W'(32);
      2: return LEN_W'($urandom_range(33, 63));
      3: return LEN_W'($urandom_range(9, 31));
      default: return LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Offers one base and waits for it to be taken. Valid stays high across back to
  // back words; an idle burst, when it comes, drops it before the word is offered.
  task automatic send_word(input logic [CHAR_W-1:0] ch, input logic second,
                           input logic last, input bit fixed = 1'b0,
                           input verdict_t fixed_v = NO_VERDICT);
    verdict_t verdict;
    if (tx_idle_en && tx_calm == 0 && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    base_char    <= ch;
    from_second  <= second;
    last_of_read <= last;
    do @(posedge clk); while (!in_ready);
    if (filter_base(ch, second, last, verdict))
      pending_verdicts.push_back(fixed ? fixed_v : verdict);
    words_sent++;
    phase_words++;
    if (tx_calm > 0) tx_calm--;
    else if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 60);
  endtask

  // One read of random bases. When a random slot's pattern fits, half the time it is
  // dropped in at a random offset; now and then a stray byte breaks the run.
  task automatic send_read(input logic second, input int len);
    int                slot;
    int                mlen;
    int                at;
    bit                embed;
    logic [CHAR_W-1:0] ch;
    slot = $urandom_range(0, SLOTS - 1);
    mlen = int'(motif_len[LEN_W*slot +: LEN_W]);
    embed = mlen >= 1 && mlen <= 32 && mlen <= len && $urandom_range(0, 1) == 1;
    at = embed ? $urandom_range(0, len - mlen) : 0;
    for (int i = 0; i < len; i++) begin
      if (embed && i >= at && i < at + mlen) ch = code_char(motif[slot][2*(i-at) +: 2]);
      else if ($urandom_range(0, 24) == 0) ch = CHAR_W'($urandom_range(0, 255));
      else ch = code_char(2'($urandom_range(0, 3)));
      send_word(ch, second, i == len - 1);
    end
  endtask

  function automatic int pick_read_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(24, 40) : $urandom_range(1, 16);
  endfunction

  // A well-formed pair, or now and then a burst of words with random flags.
  task automatic send_random_traffic();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_word(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) == 0);
    end else begin
      send_read(1'b0, pick_read_len());
      send_read(1'b1, pick_read_len());
    end
  endtask

  // Writes one register and mirrors it into the local model on acceptance.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW_BEGIN:    win_lo = int'(data[POS_W-1:0]);
      CFG_WINDOW_END:      win_hi = int'(data[POS_W-1:0]);
      CFG_PATTERN_ZERO:    motif[0] = data;
      CFG_PATTERN_ONE:     motif[1] = data;
      CFG_PATTERN_TWO:     motif[2] = data;
      CFG_PATTERN_THREE:   motif[3] = data;
      CFG_PATTERN_LENGTHS: motif_len = data[SLOTS*LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
                            input logic [HIST_W-1:0] p0, input logic [HIST_W-1:0] p1,
                            input logic [HIST_W-1:0] p2, input logic [HIST_W-1:0] p3,
                            input logic [SLOTS*LEN_W-1:0] lens);
    write_reg(CFG_WINDOW_BEGIN, CFG_DATA_W'(lo));
    write_reg(CFG_WINDOW_END, CFG_DATA_W'(hi));
    write_reg(CFG_PATTERN_ZERO, p0);
    write_reg(CFG_PATTERN_ONE, p1);
    write_reg(CFG_PATTERN_TWO, p2);
    write_reg(CFG_PATTERN_THREE, p3);
    write_reg(CFG_PATTERN_LENGTHS, CFG_DATA_W'(lens));
    cfg_valid <= 1'b0;
    setups_loaded++;
  endtask

  // Stops offering words, waits for every verdict to be matched, then lets the
  // pipeline settle so trailing words that make no result are fully absorbed.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random ready bursts, calm stretches, and on request one long hold.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (rx_idle_en && rx_calm == 0 && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(0, 29) == 0) rx_calm = $urandom_range(20, 60);
      end
    end
  end

  // Result checker. Every handshake on the output must match the oldest verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, remove_pair %0b removed_total %0d",
                 $time, remove_pair, removed_total);
      end else begin
        oldest = pending_verdicts.pop_front();
        results_checked++;
        if (oldest.remove) pairs_removed++;
        if (remove_pair !== oldest.remove) begin
          errors++;
          $display("%0t: remove_pair expected %0b, got %0b",
                   $time, oldest.remove, remove_pair);
        end
        if (removed_total !== oldest.total) begin
          errors++;
          $display("%0t: removed_total expected %0d, got %0d",
                   $time, oldest.total, removed_total);
        end
      end
    end
    if (in_valid && !in_ready) input_stall_cycles++;
  end

  initial begin
    setup_kind_e       kind;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    bit                wild;

    // Model state as reset leaves it.
    win_lo = 0;
    win_hi = int'(DEF_MAX_READ_LEN);
    for (int s = 0; s < SLOTS; s++) motif[s] = '0;
    motif_len = '0;
    seen_bases = '0;
    run_len = 0;
    read_pos = 0;
    pair_flag = 1'b0;
    removed_pairs = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // Directed table. The first pair runs on the reset configuration; then slot 0
    // holds ACGT, slot 1 is unused, slot 2 has an overlong length over all A's, and
    // slot 3 is a full 32-base run of T's.
    for (int i = 0; i < PROBE_ROWS; i++) begin
      if (i == PROBE_SETUP_ROW) begin
        finish_phase();
        load_setup(16'd0, 16'hFFFF, 64'h0000_0000_0000_00E4, '0, '0, '1,
                   {6'd32, 6'd33, 6'd0, 6'd4});
      end
      send_word(PROBE[i].ch, PROBE[i].second, PROBE[i].last, PROBE[i].fixed,
                PROBE[i].want);
    end
    finish_phase();

    // Random phases, one fresh register setting each.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = setup_kind_e'(phase % 5);
      wild = 1'b0;
      case (kind)
        SETUP_OPEN: begin
          lo = '0;
          hi = '1;
        end
        SETUP_NARROW: begin
          lo = POS_W'($urandom_range(0, 12));
          hi = lo + POS_W'($urandom_range(1, 30));
        end
        SETUP_INVERTED: begin
          lo = POS_W'($urandom_range(1, 40));
          hi = POS_W'($urandom_range(0, int'(lo)));
        end
        SETUP_LONG_MOTIFS: begin
          lo = '0;
          hi = '1;
          wild = 1'b1;
        end
        default: begin
          // Empty window at the bottom, or fully inverted from the top.
          lo = ($urandom_range(0, 1) == 1) ? '1 : '0;
          hi = '0;
        end
      endcase
      load_setup(lo, hi, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom},
                 {pick_len(wild), pick_len(wild), pick_len(wild), pick_len(wild)});

      phase_words = 0;
      if (phase == PRESSURE_PHASE) begin
        // Hold the output while one-base pairs keep arriving: the result register
        // and the queue fill, and the input must stall rather than drop words.
        hold_req = 1'b1;
        wait (holding);
        repeat (12) begin
          send_read(1'b0, 1);
          send_read(1'b1, 1);
        end
      end
      while (phase_words < PHASE_WORDS) send_random_traffic();
      // Close any pair left open by flag noise before the registers change.
      send_read(1'b1, $urandom_range(1, 8));
      finish_phase();
    end

    // Quiet tail: no idling on either side from here on.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;

    load_setup('0, '1, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom},
               {pick_len(1'b0), pick_len(1'b0), pick_len(1'b0), pick_len(1'b0)});
    phase_words = 0;
    while (phase_words < 60) send_random_traffic();
    send_read(1'b1, 1);
    finish_phase();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bases under %0d register settings; %0d pair verdicts checked,",
             words_sent, setups_loaded, results_checked);
    $display("%0d pairs removed; input was held off for %0d cycles by output back-pressure.",
             pairs_removed, input_stall_cycles);
    if (errors == 0) begin
      $display("tb_paired_read_pattern_filter_unit: PASS");
    end else begin
      $display("tb_paired_read_pattern_filter_unit: FAIL");
    end
    $finish;
  end

endmodule

### paired_read_pattern_filter_unit.f
hw/rtl/prpf_pkg.sv
hw/rtl/prpf_front.sv
hw/rtl/prpf_queue.sv
hw/rtl/prpf_back.sv
hw/rtl/paired_read_pattern_filter_unit.sv
tb/tb_paired_read_pattern_filter_unit.sv
